### rtl/tq_pkg.sv
`timescale 1ns / 1ps

package tq_pkg;

	// Default sizes of the queue.
	localparam int DEPTH_DEF      = 16;
	localparam int TIME_WIDTH_DEF = 32;

	// Fixed port widths.
	localparam int TAG_W       = 16;
	localparam int TIME_PORT_W = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_POPPED     = 3'd2,
		ST_NONE_READY = 3'd3,
		ST_REMOVED    = 3'd4,
		ST_NOT_FOUND  = 3'd5
	} status_t;

	// Flags from the shared compare unit.
	typedef struct packed {
		logic time_lt;
		logic tag_eq;
	} cmp_res_t;

endpackage

### rtl/tq_mem.sv
`timescale 1ns / 1ps

module tq_mem #(
	parameter int DEPTH      = tq_pkg::DEPTH_DEF,
	parameter int TIME_WIDTH = tq_pkg::TIME_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [tq_pkg::TAG_W-1:0] wtag,
	input  logic [TIME_WIDTH-1:0]   wtime,
	input  logic [AW-1:0]           raddr,
	output logic [tq_pkg::TAG_W-1:0] rtag,
	output logic [TIME_WIDTH-1:0]   rtime
);

	logic [tq_pkg::TAG_W-1:0] tag_mem [DEPTH];
	logic [TIME_WIDTH-1:0]    time_mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr]  <= wtag;
			time_mem[waddr] <= wtime;
		end
		rtag  <= tag_mem[raddr];
		rtime <= time_mem[raddr];
	end

endmodule

### rtl/tq_cmp.sv
`timescale 1ns / 1ps

module tq_cmp #(
	parameter int TIME_WIDTH = tq_pkg::TIME_WIDTH_DEF
) (
	input  logic [TIME_WIDTH-1:0]    a_time,
	input  logic [TIME_WIDTH-1:0]    b_time,
	input  logic [tq_pkg::TAG_W-1:0] a_tag,
	input  logic [tq_pkg::TAG_W-1:0] b_tag,
	output tq_pkg::cmp_res_t         res
);

	// Unsigned time order and tag match, shared by every walk of the sequencer.
	always_comb begin
		res.time_lt = (a_time < b_time);
		res.tag_eq  = (a_tag == b_tag);
	end

endmodule

### rtl/time_ordered_task_queue.sv
`timescale 1ns / 1ps

// Channel   Ports                                       Handshake
// request   op, task_tag, due_time, now_time            start high while busy low
// result    status, out_tag, out_due_time, fill_count   done high for one cycle
//
// A request settled by the fill count alone (full or empty queue, unused code) gives done
// in the cycle after acceptance. Any other insert walks back from the tail, moving each
// entry due no earlier than the new task one place down. A pop or a remove walks the held
// entries through the single read port of the memory.
// Reset empties the queue at once; the entry memory itself is not cleared.
// The receiver cannot stall: a result is shown for exactly one cycle.
module time_ordered_task_queue #(
	parameter int DEPTH      = tq_pkg::DEPTH_DEF,
	parameter int TIME_WIDTH = tq_pkg::TIME_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [tq_pkg::OP_W-1:0]        op,
	input  logic [tq_pkg::TAG_W-1:0]       task_tag,
	input  logic [tq_pkg::TIME_PORT_W-1:0] due_time,
	input  logic [tq_pkg::TIME_PORT_W-1:0] now_time,
	output logic                           done,
	output logic [tq_pkg::STATUS_W-1:0]    status,
	output logic [tq_pkg::TAG_W-1:0]       out_tag,
	output logic [tq_pkg::TIME_PORT_W-1:0] out_due_time,
	output logic [CW-1:0]                  fill_count
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_HEAD     = 5'b00010,
		S_INS      = 5'b00100,
		S_INS_LAST = 5'b01000,
		S_WALK     = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [CW-1:0]            k_q, k_d;
	logic [CW-1:0]            wr_q, wr_d;
	logic                     found_q, found_d;
	logic                     pop_q, pop_d;
	logic [tq_pkg::TAG_W-1:0] tag_q, tag_d;
	logic [TIME_WIDTH-1:0]    due_q, due_d;
	logic [TIME_WIDTH-1:0]    now_q, now_d;
	logic                     done_q, done_d;
	tq_pkg::status_t          status_q, status_d;
	logic [tq_pkg::TAG_W-1:0] otag_q, otag_d;
	logic [TIME_WIDTH-1:0]    otime_q, otime_d;

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [tq_pkg::TAG_W-1:0] mem_wtag;
	logic [TIME_WIDTH-1:0]    mem_wtime;
	logic [AW-1:0]            mem_raddr;
	logic [tq_pkg::TAG_W-1:0] rtag;
	logic [TIME_WIDTH-1:0]    rtime;

	logic [TIME_WIDTH-1:0]    cmp_a;
	logic [TIME_WIDTH-1:0]    cmp_b;
	tq_pkg::cmp_res_t         cmp;

	logic [CW-1:0]            cnt_m1;
	logic [CW-1:0]            k_m1;
	logic [CW-1:0]            k_m2;
	logic [CW-1:0]            k_p1;
	logic [CW-1:0]            wr_p1;
	logic                     skip;

	tq_mem #(
		.DEPTH      (DEPTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wtag  (mem_wtag),
		.wtime (mem_wtime),
		.raddr (mem_raddr),
		.rtag  (rtag),
		.rtime (rtime)
	);

	tq_cmp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_cmp (
		.a_time (cmp_a),
		.b_time (cmp_b),
		.a_tag  (rtag),
		.b_tag  (tag_q),
		.res    (cmp)
	);

	assign cnt_m1 = cnt_q - CW'(1);
	assign k_m1   = k_q - CW'(1);
	assign k_m2   = k_q - CW'(2);
	assign k_p1   = k_q + CW'(1);
	assign wr_p1  = wr_q + CW'(1);
	assign skip   = !pop_q && cmp.tag_eq;

	// Sequencer: decides the memory access, the compare operands and the next state.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		k_d       = k_q;
		wr_d      = wr_q;
		found_d   = found_q;
		pop_d     = pop_q;
		tag_d     = tag_q;
		due_d     = due_q;
		now_d     = now_q;
		done_d    = 1'b0;
		status_d  = status_q;
		otag_d    = otag_q;
		otime_d   = otime_q;
		mem_we    = 1'b0;
		mem_waddr = wr_q[AW-1:0];
		mem_wtag  = rtag;
		mem_wtime = rtime;
		mem_raddr = '0;
		cmp_a     = rtime;
		cmp_b     = due_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					tag_d   = task_tag;
					due_d   = TIME_WIDTH'(due_time);
					now_d   = TIME_WIDTH'(now_time);
					otag_d  = '0;
					otime_d = '0;
					found_d = 1'b0;
					wr_d    = '0;
					case (op)
						tq_pkg::OP_INSERT: begin
							if (cnt_q == CW'(DEPTH)) begin
								status_d = tq_pkg::ST_FULL;
								done_d   = 1'b1;
							end else if (cnt_q == '0) begin
								// Empty queue: the new task becomes the head directly.
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wtag  = task_tag;
								mem_wtime = TIME_WIDTH'(due_time);
								cnt_d     = CW'(1);
								status_d  = tq_pkg::ST_INSERTED;
								done_d    = 1'b1;
							end else begin
								k_d       = cnt_q;
								mem_raddr = cnt_m1[AW-1:0];
								state_d   = S_INS;
							end
						end
						tq_pkg::OP_POP: begin
							if (cnt_q == '0) begin
								status_d = tq_pkg::ST_NONE_READY;
								done_d   = 1'b1;
							end else begin
								mem_raddr = '0;
								state_d   = S_HEAD;
							end
						end
						tq_pkg::OP_REMOVE: begin
							if (cnt_q == '0) begin
								status_d = tq_pkg::ST_NOT_FOUND;
								done_d   = 1'b1;
							end else begin
								mem_raddr = '0;
								k_d       = '0;
								pop_d     = 1'b0;
								state_d   = S_WALK;
							end
						end
						default: begin
							status_d = tq_pkg::ST_NOT_FOUND;
							done_d   = 1'b1;
						end
					endcase
				end
			end
			S_INS: begin
				// Walk back from the tail, moving entries due at the same time or later one place down.
				mem_raddr = k_m2[AW-1:0];
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				if (!cmp.time_lt) begin
					k_d = k_m1;
					if (k_q == CW'(1)) begin
						state_d = S_INS_LAST;
					end
				end else begin
					mem_wtag  = tag_q;
					mem_wtime = due_q;
					cnt_d     = cnt_q + CW'(1);
					status_d  = tq_pkg::ST_INSERTED;
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_INS_LAST: begin
				// Every held entry is due no earlier, so the new task takes the head.
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wtag  = tag_q;
				mem_wtime = due_q;
				cnt_d     = cnt_q + CW'(1);
				status_d  = tq_pkg::ST_INSERTED;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			S_HEAD: begin
				// The head is due when the current time is not below its due time.
				cmp_a     = now_q;
				cmp_b     = rtime;
				mem_raddr = AW'(1);
				if (cmp.time_lt) begin
					status_d = tq_pkg::ST_NONE_READY;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					otag_d  = rtag;
					otime_d = rtime;
					if (cnt_q == CW'(1)) begin
						cnt_d    = '0;
						status_d = tq_pkg::ST_POPPED;
						done_d   = 1'b1;
						state_d  = S_IDLE;
					end else begin
						k_d     = CW'(1);
						pop_d   = 1'b1;
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				// Compact the entries toward the head, dropping matching tags on a remove.
				mem_raddr = k_p1[AW-1:0];
				if (skip) begin
					found_d = 1'b1;
				end else begin
					mem_we = 1'b1;
					wr_d   = wr_p1;
				end
				if (k_q == cnt_m1) begin
					cnt_d  = skip ? wr_q : wr_p1;
					done_d = 1'b1;
					if (pop_q) begin
						status_d = tq_pkg::ST_POPPED;
					end else if (found_q || skip) begin
						status_d = tq_pkg::ST_REMOVED;
					end else begin
						status_d = tq_pkg::ST_NOT_FOUND;
					end
					state_d = S_IDLE;
				end else begin
					k_d = k_p1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	// Working and result payload.
	always_ff @(posedge clk) begin
		k_q      <= k_d;
		wr_q     <= wr_d;
		found_q  <= found_d;
		pop_q    <= pop_d;
		tag_q    <= tag_d;
		due_q    <= due_d;
		now_q    <= now_d;
		status_q <= status_d;
		otag_q   <= otag_d;
		otime_q  <= otime_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_tag      = otag_q;
	assign out_due_time = tq_pkg::TIME_PORT_W'(otime_q);
	assign fill_count   = cnt_q;

endmodule

### sim/tb_time_ordered_task_queue.sv
`timescale 1ns / 1ps

module tb_time_ordered_task_queue;

	localparam int DEPTH       = tq_pkg::DEPTH_DEF;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int OP_W        = tq_pkg::OP_W;
	localparam int TAG_W       = tq_pkg::TAG_W;
	localparam int TIME_PORT_W = tq_pkg::TIME_PORT_W;
	localparam int STATUS_W    = tq_pkg::STATUS_W;

	// Op code that the block must treat as a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_REQUESTS = 1800;
	localparam int IDLE_LIMIT      = 2000;
	localparam int TAIL_CYCLES     = DEPTH + 4;

	localparam logic [TIME_PORT_W-1:0] T_MAX = '1;

	// Random traffic mixes.
	localparam int MIX_FILL    = 0;
	localparam int MIX_DRAIN   = 1;
	localparam int MIX_BALANCE = 2;

	typedef struct {
		tq_pkg::status_t        status;
		logic [TAG_W-1:0]       tag;
		logic [TIME_PORT_W-1:0] due;
		logic [CW-1:0]          fill;
	} result_t;

	typedef struct {
		logic [OP_W-1:0]        op;
		logic [TAG_W-1:0]       tag;
		logic [TIME_PORT_W-1:0] due;
		logic [TIME_PORT_W-1:0] now;
		int                     reps;
		bit                     typed;
		result_t                res;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [OP_W-1:0]        op;
	logic [TAG_W-1:0]       task_tag;
	logic [TIME_PORT_W-1:0] due_time;
	logic [TIME_PORT_W-1:0] now_time;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	logic [TAG_W-1:0]       out_tag;
	logic [TIME_PORT_W-1:0] out_due_time;
	logic [CW-1:0]          fill_count;

	// Shadow copy of the sorted task list, index 0 is the head.
	logic [TAG_W-1:0]       sched_tags [DEPTH];
	logic [TIME_PORT_W-1:0] sched_times [DEPTH];
	int                     sched_count;

	result_t   awaited_results [$];
	stim_row_t plan [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        no_idle = 1'b0;

	time_ordered_task_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.task_tag     (task_tag),
		.due_time     (due_time),
		.now_time     (now_time),
		.done         (done),
		.status       (status),
		.out_tag      (out_tag),
		.out_due_time (out_due_time),
		.fill_count   (fill_count)
	);

	always #2 clk = ~clk;

	// Apply one accepted request to the shadow list and return the result it must give.
	function automatic result_t advance_schedule(logic [OP_W-1:0] o, logic [TAG_W-1:0] t,
			logic [TIME_PORT_W-1:0] d, logic [TIME_PORT_W-1:0] n);
		result_t r;
		int      pos;
		int      k;
		int      wr;
		bit      hit;
		r.status = tq_pkg::ST_NOT_FOUND;
		r.tag    = '0;
		r.due    = '0;
		case (o)
			tq_pkg::OP_INSERT: begin
				if (sched_count >= DEPTH) begin
					r.status = tq_pkg::ST_FULL;
				end else begin
					// New task goes ahead of the first entry due at the same time or later.
					pos = 0;
					while (pos < sched_count && sched_times[pos] < d)
						pos++;
					for (k = sched_count; k > pos; k--) begin
						sched_tags[k]  = sched_tags[k-1];
						sched_times[k] = sched_times[k-1];
					end
					sched_tags[pos]  = t;
					sched_times[pos] = d;
					sched_count++;
					r.status = tq_pkg::ST_INSERTED;
				end
			end
			tq_pkg::OP_POP: begin
				if (sched_count == 0 || sched_times[0] > n) begin
					r.status = tq_pkg::ST_NONE_READY;
				end else begin
					r.tag = sched_tags[0];
					r.due = sched_times[0];
					for (k = 1; k < sched_count; k++) begin
						sched_tags[k-1]  = sched_tags[k];
						sched_times[k-1] = sched_times[k];
					end
					sched_count--;
					r.status = tq_pkg::ST_POPPED;
				end
			end
			tq_pkg::OP_REMOVE: begin
				// Compact the list, dropping every entry with a matching tag.
				wr  = 0;
				hit = 1'b0;
				for (k = 0; k < sched_count; k++) begin
					if (sched_tags[k] == t) begin
						hit = 1'b1;
					end else begin
						sched_tags[wr]  = sched_tags[k];
						sched_times[wr] = sched_times[k];
						wr++;
					end
				end
				sched_count = wr;
				r.status = hit ? tq_pkg::ST_REMOVED : tq_pkg::ST_NOT_FOUND;
			end
			default: begin
				r.status = tq_pkg::ST_NOT_FOUND;
			end
		endcase
		r.fill = CW'(sched_count);
		return r;
	endfunction

	function automatic void add_row(logic [OP_W-1:0] o, logic [TAG_W-1:0] t,
			logic [TIME_PORT_W-1:0] d, logic [TIME_PORT_W-1:0] n, int reps, bit typed,
			tq_pkg::status_t st, logic [TAG_W-1:0] rt, logic [TIME_PORT_W-1:0] rd, int fill);
		stim_row_t row;
		row.op         = o;
		row.tag        = t;
		row.due        = d;
		row.now        = n;
		row.reps       = reps;
		row.typed      = typed;
		row.res.status = st;
		row.res.tag    = rt;
		row.res.due    = rd;
		row.res.fill   = CW'(fill);
		plan.insert(plan.size(), row);
	endfunction

	// Send one request after a random gap and record what it must return.
	task automatic issue_request(logic [OP_W-1:0] o, logic [TAG_W-1:0] t,
			logic [TIME_PORT_W-1:0] d, logic [TIME_PORT_W-1:0] n, bit typed, result_t want);
		int      gap;
		result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			start    <= 1'b0;
			op       <= OP_W'($urandom);
			task_tag <= TAG_W'($urandom);
			due_time <= $urandom;
			now_time <= $urandom;
		end
		@(negedge clk);
		start    <= 1'b1;
		op       <= o;
		task_tag <= t;
		due_time <= d;
		now_time <= n;
		do
			@(posedge clk);
		while (busy);
		predicted = advance_schedule(o, t, d, n);
		awaited_results.insert(awaited_results.size(), typed ? want : predicted);
	endtask

	// Compare each result strobe with the oldest pending expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request pending: status %0d tag %0h", status, out_tag);
				mismatches++;
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (out_tag !== want.tag) begin
					$error("out_tag: expected %0h, got %0h", want.tag, out_tag);
					mismatches++;
				end
				if (out_due_time !== want.due) begin
					$error("out_due_time: expected %0h, got %0h", want.due, out_due_time);
					mismatches++;
				end
				if (fill_count !== want.fill) begin
					$error("fill_count: expected %0d, got %0d", want.fill, fill_count);
					mismatches++;
				end
			end
		end
	end

	// End the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int                     i;
		int                     k;
		int                     mix;
		int                     roll;
		int                     ins_pct;
		int                     pop_pct;
		int                     rem_pct;
		logic [OP_W-1:0]        r_op;
		logic [TAG_W-1:0]       r_tag;
		logic [TIME_PORT_W-1:0] r_due;
		logic [TIME_PORT_W-1:0] r_now;
		logic [TIME_PORT_W-1:0] head;
		result_t                none;

		arst_n      = 1'b0;
		start       = 1'b0;
		op          = tq_pkg::OP_INSERT;
		task_tag    = '0;
		due_time    = '0;
		now_time    = '0;
		sched_count = 0;
		none.status = tq_pkg::ST_NOT_FOUND;
		none.tag    = '0;
		none.due    = '0;
		none.fill   = '0;

		// Directed requests: empty queue, extremes, ordering among equal times, full, removal.
		add_row(tq_pkg::OP_POP, 16'h0000, '0, T_MAX, 1, 1, tq_pkg::ST_NONE_READY, '0, '0, 0);
		add_row(tq_pkg::OP_REMOVE, 16'h0000, '0, '0, 1, 1, tq_pkg::ST_NOT_FOUND, '0, '0, 0);
		add_row(OP_UNUSED, 16'hFFFF, T_MAX, T_MAX, 1, 1, tq_pkg::ST_NOT_FOUND, '0, '0, 0);
		add_row(tq_pkg::OP_INSERT, 16'hFFFF, T_MAX, '0, 1, 1, tq_pkg::ST_INSERTED, '0, '0, 1);
		add_row(tq_pkg::OP_INSERT, 16'h0000, '0, T_MAX, 1, 1, tq_pkg::ST_INSERTED, '0, '0, 2);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, '0, 1, 1, tq_pkg::ST_POPPED, '0, '0, 1);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, T_MAX - 1, 1, 1, tq_pkg::ST_NONE_READY,
			'0, '0, 1);
		add_row(tq_pkg::OP_INSERT, 16'h0001, 32'd100, '0, 1, 0, tq_pkg::ST_INSERTED,
			'0, '0, 0);
		add_row(tq_pkg::OP_INSERT, 16'h0002, 32'd100, '0, 1, 0, tq_pkg::ST_INSERTED,
			'0, '0, 0);
		add_row(tq_pkg::OP_INSERT, 16'h0003, 32'd50, '0, 1, 0, tq_pkg::ST_INSERTED,
			'0, '0, 0);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, 32'd49, 1, 1, tq_pkg::ST_NONE_READY, '0, '0, 4);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, 32'd50, 1, 1, tq_pkg::ST_POPPED,
			16'h0003, 32'd50, 3);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, 32'd100, 1, 0, tq_pkg::ST_POPPED, '0, '0, 0);
		add_row(tq_pkg::OP_INSERT, 16'h0007, 32'd200, '0, 14, 0, tq_pkg::ST_INSERTED,
			'0, '0, 0);
		add_row(tq_pkg::OP_INSERT, 16'h0009, '0, '0, 1, 1, tq_pkg::ST_FULL, '0, '0, 16);
		add_row(tq_pkg::OP_REMOVE, 16'h0007, '0, '0, 1, 1, tq_pkg::ST_REMOVED, '0, '0, 2);
		add_row(tq_pkg::OP_REMOVE, 16'h0007, '0, '0, 1, 1, tq_pkg::ST_NOT_FOUND, '0, '0, 2);
		add_row(OP_UNUSED, 16'h0001, '0, T_MAX, 1, 1, tq_pkg::ST_NOT_FOUND, '0, '0, 2);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, T_MAX, 1, 0, tq_pkg::ST_POPPED, '0, '0, 0);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, T_MAX, 1, 1, tq_pkg::ST_POPPED,
			16'hFFFF, T_MAX, 0);
		add_row(tq_pkg::OP_POP, 16'h0000, '0, T_MAX, 1, 1, tq_pkg::ST_NONE_READY, '0, '0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[r])
			for (k = 0; k < plan[r].reps; k++)
				issue_request(plan[r].op, plan[r].tag, plan[r].due, plan[r].now,
					plan[r].typed, plan[r].res);

		// Random traffic in phases that push the fill level up, down, or hold it steady.
		mix = MIX_BALANCE;
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 120 == 0) begin
				mix     = $urandom_range(MIX_FILL, MIX_BALANCE);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			case (mix)
				MIX_FILL:  begin ins_pct = 70; pop_pct = 15; rem_pct = 11; end
				MIX_DRAIN: begin ins_pct = 20; pop_pct = 60; rem_pct = 16; end
				default:   begin ins_pct = 42; pop_pct = 35; rem_pct = 19; end
			endcase

			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				r_op = tq_pkg::OP_INSERT;
			else if (roll < ins_pct + pop_pct)
				r_op = tq_pkg::OP_POP;
			else if (roll < ins_pct + pop_pct + rem_pct)
				r_op = tq_pkg::OP_REMOVE;
			else
				r_op = OP_UNUSED;

			// A small tag pool makes removals hit several entries.
			if ($urandom_range(0, 4) == 0)
				r_tag = TAG_W'($urandom);
			else
				r_tag = TAG_W'($urandom_range(0, 15));
			if (r_op == tq_pkg::OP_REMOVE && sched_count > 0 && $urandom_range(0, 9) < 7)
				r_tag = sched_tags[$urandom_range(0, sched_count - 1)];

			case ($urandom_range(0, 5))
				0:       r_due = '0;
				1:       r_due = T_MAX;
				2, 3:    r_due = $urandom_range(0, 63);
				default: r_due = $urandom;
			endcase

			// Aim the current time at the head's due time to probe the ready boundary.
			if (sched_count > 0) begin
				head = sched_times[0];
				case ($urandom_range(0, 5))
					0:       r_now = head;
					1:       r_now = head - 1;
					2:       r_now = T_MAX;
					3:       r_now = '0;
					4:       r_now = $urandom_range(0, 63);
					default: r_now = $urandom;
				endcase
			end else begin
				r_now = $urandom;
			end

			issue_request(r_op, r_tag, r_due, r_now, 1'b0, none);
		end

		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
